### rtl/lrp_pkg.sv
package lrp_pkg;

  // Table geometry and key width
  localparam int MAX_ROWS     = 64;
  localparam int KEY_BITS     = 16;
  localparam int ROW_BITS     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // Fixed widths of the command and result fields
  localparam int CFG_BITS     = 7;
  localparam int ROW_IDX_BITS = 6;
  localparam int KEY_IO_BITS  = 16;

  // Row counts need to hold MAX_ROWS itself and the full config value
  localparam int CNT_W = (CFG_BITS > ROW_BITS + 1) ? CFG_BITS : ROW_BITS + 1;

  // Command codes carried on func
  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_STEP    = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_RESTORE = 2'd3
  } func_e;

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [ROW_BITS-1:0]        row_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  // Row store (position -> origin, previous position) requests
  typedef struct packed {
    logic rd_en;
    row_t rd_addr;
    logic wr_en;
    row_t wr_addr;
    row_t wr_origin;
    row_t wr_prev;
    logic clr_all;
    logic clr_prev;
    cnt_t clr_limit;
  } row_req_t;

  typedef struct packed {
    row_t origin;
    row_t prev;
  } row_rsp_t;

  // Key store (origin -> key) requests
  typedef struct packed {
    logic rd_en;
    row_t rd_addr;
    logic wr_en;
    row_t wr_addr;
    key_t wr_key;
  } key_req_t;

endpackage

### rtl/lrp_row_store.sv
module lrp_row_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lrp_pkg::row_req_t  req_i,
  output lrp_pkg::row_rsp_t  rsp_o
);

  localparam int RB = lrp_pkg::ROW_BITS;

  logic [2*RB-1:0]              mem_q [lrp_pkg::MAX_ROWS];
  logic [2*RB-1:0]              data_q;
  lrp_pkg::row_t                addr_q;
  logic [lrp_pkg::MAX_ROWS-1:0] org_v_q;
  logic [lrp_pkg::MAX_ROWS-1:0] prv_v_q;
  logic                         rd_org_v_q;
  logic                         rd_prv_v_q;

  // Row memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= {req_i.wr_origin, req_i.wr_prev};
    end
    if (req_i.rd_en) begin
      data_q <= mem_q[req_i.rd_addr];
      addr_q <= req_i.rd_addr;
    end
  end

  // Valid bits: an invalid entry reads as the identity row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_v_q    <= '0;
      prv_v_q    <= '0;
      rd_org_v_q <= 1'b0;
      rd_prv_v_q <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rd_org_v_q <= org_v_q[req_i.rd_addr];
        rd_prv_v_q <= prv_v_q[req_i.rd_addr];
      end
      for (int i = 0; i < lrp_pkg::MAX_ROWS; i++) begin
        if (req_i.clr_all) begin
          org_v_q[i] <= 1'b0;
          prv_v_q[i] <= 1'b0;
        end else if (req_i.clr_prev && (lrp_pkg::CNT_W'(i) < req_i.clr_limit)) begin
          prv_v_q[i] <= 1'b0;
        end
      end
      if (req_i.wr_en) begin
        org_v_q[req_i.wr_addr] <= 1'b1;
        prv_v_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign rsp_o.origin = rd_org_v_q ? data_q[2*RB-1:RB] : addr_q;
  assign rsp_o.prev   = rd_prv_v_q ? data_q[RB-1:0]    : addr_q;

endmodule

### rtl/lrp_key_store.sv
module lrp_key_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrp_pkg::key_req_t req_i,
  output lrp_pkg::key_t     key_o
);

  lrp_pkg::key_t                mem_q [lrp_pkg::MAX_ROWS];
  lrp_pkg::key_t                data_q;
  logic [lrp_pkg::MAX_ROWS-1:0] key_v_q;
  logic                         rd_v_q;

  // Key memory indexed by a row's original index
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_key;
    end
    if (req_i.rd_en) begin
      data_q <= mem_q[req_i.rd_addr];
    end
  end

  // Keys never written read as minus one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_v_q <= '0;
      rd_v_q  <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rd_v_q <= key_v_q[req_i.rd_addr];
      end
      if (req_i.wr_en) begin
        key_v_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign key_o = rd_v_q ? data_q : '1;

endmodule

### rtl/lexicographic_row_permuter_unit.sv
// Write key, read row and restore each end with a closing pivot scan over the active rows
//   that reads one row per cycle through both memories.
// Step: pivot scan, successor scan, then row swaps on the row memory (read A, read B,
//   write A, write B per swap), then the closing pivot scan.
// One command at a time; the result strobe is one cycle wide and cannot be stalled.
// Reset: table holds the identity order with all keys -1 at once, no clearing pass.
module lexicographic_row_permuter_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             func_i,
  input  logic [lrp_pkg::ROW_IDX_BITS-1:0]       row_index_i,
  input  logic signed [lrp_pkg::KEY_IO_BITS-1:0] key_value_i,
  output logic                                   done_o,
  output logic signed [lrp_pkg::KEY_IO_BITS-1:0] key_out_o,
  output logic [lrp_pkg::ROW_IDX_BITS-1:0]       origin_out_o,
  output logic [lrp_pkg::ROW_IDX_BITS-1:0]       previous_out_o,
  output logic                                   applied_o,
  output logic                                   more_left_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [lrp_pkg::CFG_BITS-1:0]           cfg_data_i
);

  localparam int RB    = lrp_pkg::ROW_BITS;
  localparam int CW    = lrp_pkg::CNT_W;
  localparam int IDX_W = (lrp_pkg::ROW_IDX_BITS > RB + 1) ? lrp_pkg::ROW_IDX_BITS : RB + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW_RD,
    ST_KEY_OP,
    ST_KEY_RD,
    ST_RESTORE,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_SWAP_RA,
    ST_SWAP_RB,
    ST_SWAP_WA,
    ST_SWAP_WB
  } state_e;

  // What the current scan is looking for
  typedef enum logic [1:0] {
    SK_FINAL,
    SK_PIVOT,
    SK_SUCC
  } scan_kind_e;

  state_e                              state_q;
  scan_kind_e                          kind_q;
  logic                                busy_q;
  logic                                done_q;
  logic [lrp_pkg::CFG_BITS-1:0]        rows_q;

  lrp_pkg::func_e                      cmd_func_q;
  lrp_pkg::row_t                       cmd_row_q;
  lrp_pkg::key_t                       cmd_key_q;

  logic signed [lrp_pkg::KEY_IO_BITS-1:0] key_out_q;
  logic [lrp_pkg::ROW_IDX_BITS-1:0]    origin_out_q;
  logic [lrp_pkg::ROW_IDX_BITS-1:0]    prev_out_q;
  logic                                applied_q;
  logic                                more_q;

  // Scan pipeline: issue row read, then key read, then compare
  lrp_pkg::row_t                       ip_q;
  lrp_pkg::cnt_t                       left_q;
  logic                                s1_vld_q;
  lrp_pkg::row_t                       s1_pos_q;
  logic                                s2_vld_q;
  lrp_pkg::row_t                       s2_pos_q;
  lrp_pkg::key_t                       last_key_q;
  logic                                have_last_q;
  lrp_pkg::row_t                       pivot_q;
  lrp_pkg::key_t                       pivot_key_q;

  // Swap sequencer
  lrp_pkg::row_t                       lo_q;
  lrp_pkg::row_t                       hi_q;
  logic                                first_q;
  lrp_pkg::row_rsp_t                   hold_q;

  lrp_pkg::row_req_t                   row_req;
  lrp_pkg::row_rsp_t                   row_rsp;
  lrp_pkg::key_req_t                   key_req;
  lrp_pkg::key_t                       key_rsp;

  lrp_pkg::cnt_t                       cfg_ext;
  lrp_pkg::cnt_t                       n_act;
  logic                                accept;
  logic                                row_ok;
  logic                                scan_hit;
  logic                                scan_end;
  lrp_pkg::row_t                       lo_nxt;
  lrp_pkg::row_t                       hi_nxt;

  // Active row count, clamped to the table size
  assign cfg_ext = CW'(rows_q);
  assign n_act   = (cfg_ext > CW'(lrp_pkg::MAX_ROWS)) ? CW'(lrp_pkg::MAX_ROWS) : cfg_ext;

  assign accept = start && !busy_q;
  assign row_ok = IDX_W'(row_index_i) < IDX_W'(lrp_pkg::MAX_ROWS);

  // Scan compare on the key coming out of the key store
  always_comb begin
    if (kind_q == SK_SUCC) begin
      scan_hit = s2_vld_q && ($signed(key_rsp) > $signed(pivot_key_q));
    end else begin
      scan_hit = s2_vld_q && have_last_q && ($signed(key_rsp) < $signed(last_key_q));
    end
    scan_end = (state_q == ST_SCAN) && s2_vld_q && (scan_hit || (s2_pos_q == '0));
  end

  // Next swap pair: pivot/successor first, then the suffix reversal
  assign lo_nxt = first_q ? RB'(pivot_q + 1'b1) : RB'(lo_q + 1'b1);
  assign hi_nxt = first_q ? RB'(n_act - 1'b1)   : RB'(hi_q - 1'b1);

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= lrp_pkg::CFG_BITS'(64);
    end else if (cfg_valid_i && cfg_ready_o) begin
      rows_q <= cfg_data_i;
    end
  end

  // Memory requests from the sequencer
  always_comb begin
    row_req           = '0;
    row_req.clr_limit = n_act;
    key_req           = '0;
    unique case (state_q)
      ST_ROW_RD: begin
        row_req.rd_en   = 1'b1;
        row_req.rd_addr = cmd_row_q;
      end
      ST_KEY_OP: begin
        if (cmd_func_q == lrp_pkg::FUNC_READ) begin
          key_req.rd_en   = 1'b1;
          key_req.rd_addr = row_rsp.origin;
        end else begin
          key_req.wr_en   = 1'b1;
          key_req.wr_addr = row_rsp.origin;
          key_req.wr_key  = cmd_key_q;
        end
      end
      ST_RESTORE: begin
        row_req.clr_all = 1'b1;
      end
      ST_SCAN: begin
        row_req.rd_en    = (left_q != '0);
        row_req.rd_addr  = ip_q;
        key_req.rd_en    = s1_vld_q;
        key_req.rd_addr  = row_rsp.origin;
        row_req.clr_prev = scan_end && (kind_q == SK_SUCC);
      end
      ST_SWAP_RA: begin
        row_req.rd_en   = 1'b1;
        row_req.rd_addr = lo_q;
      end
      ST_SWAP_RB: begin
        row_req.rd_en   = 1'b1;
        row_req.rd_addr = hi_q;
      end
      ST_SWAP_WA: begin
        row_req.wr_en     = 1'b1;
        row_req.wr_addr   = lo_q;
        row_req.wr_origin = row_rsp.origin;
        row_req.wr_prev   = row_rsp.prev;
      end
      ST_SWAP_WB: begin
        row_req.wr_en     = 1'b1;
        row_req.wr_addr   = hi_q;
        row_req.wr_origin = hold_q.origin;
        row_req.wr_prev   = hold_q.prev;
      end
      ST_IDLE, ST_KEY_RD, ST_SCAN_INIT: begin
      end
    endcase
  end

  // Command sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= SK_FINAL;
      busy_q       <= 1'b0;
      done_q       <= 1'b0;
      cmd_func_q   <= lrp_pkg::FUNC_WRITE;
      cmd_row_q    <= '0;
      cmd_key_q    <= '0;
      key_out_q    <= '0;
      origin_out_q <= '0;
      prev_out_q   <= '0;
      applied_q    <= 1'b0;
      more_q       <= 1'b0;
      ip_q         <= '0;
      left_q       <= '0;
      s1_vld_q     <= 1'b0;
      s1_pos_q     <= '0;
      s2_vld_q     <= 1'b0;
      s2_pos_q     <= '0;
      last_key_q   <= '0;
      have_last_q  <= 1'b0;
      pivot_q      <= '0;
      pivot_key_q  <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      first_q      <= 1'b0;
      hold_q       <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            busy_q       <= 1'b1;
            cmd_func_q   <= lrp_pkg::func_e'(func_i);
            cmd_row_q    <= RB'(row_index_i);
            cmd_key_q    <= lrp_pkg::KEY_BITS'(key_value_i);
            key_out_q    <= '0;
            origin_out_q <= '0;
            prev_out_q   <= '0;
            applied_q    <= 1'b0;
            unique case (func_i)
              lrp_pkg::FUNC_WRITE, lrp_pkg::FUNC_READ: begin
                kind_q  <= SK_FINAL;
                state_q <= row_ok ? ST_ROW_RD : ST_SCAN_INIT;
              end
              lrp_pkg::FUNC_STEP: begin
                kind_q  <= SK_PIVOT;
                state_q <= ST_SCAN_INIT;
              end
              lrp_pkg::FUNC_RESTORE: begin
                state_q <= ST_RESTORE;
              end
            endcase
          end
        end
        ST_ROW_RD: begin
          state_q <= ST_KEY_OP;
        end
        ST_KEY_OP: begin
          if (cmd_func_q == lrp_pkg::FUNC_READ) begin
            origin_out_q <= lrp_pkg::ROW_IDX_BITS'(row_rsp.origin);
            prev_out_q   <= lrp_pkg::ROW_IDX_BITS'(row_rsp.prev);
            state_q      <= ST_KEY_RD;
          end else begin
            state_q <= ST_SCAN_INIT;
          end
        end
        ST_KEY_RD: begin
          key_out_q <= lrp_pkg::KEY_IO_BITS'($signed(key_rsp));
          state_q   <= ST_SCAN_INIT;
        end
        ST_RESTORE: begin
          kind_q  <= SK_FINAL;
          state_q <= ST_SCAN_INIT;
        end
        ST_SCAN_INIT: begin
          s1_vld_q    <= 1'b0;
          s2_vld_q    <= 1'b0;
          have_last_q <= 1'b0;
          ip_q        <= RB'(n_act - 1'b1);
          if (kind_q == SK_SUCC) begin
            left_q  <= CW'(n_act - CW'(pivot_q) - 1'b1);
            state_q <= ST_SCAN;
          end else if (n_act < CW'(2)) begin
            // fewer than two rows: nothing to permute
            more_q  <= 1'b0;
            done_q  <= 1'b1;
            busy_q  <= 1'b0;
            state_q <= ST_IDLE;
          end else begin
            left_q  <= n_act;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (left_q != '0) begin
            ip_q   <= ip_q - 1'b1;
            left_q <= left_q - 1'b1;
          end
          s1_vld_q <= (left_q != '0);
          s1_pos_q <= ip_q;
          s2_vld_q <= s1_vld_q;
          s2_pos_q <= s1_pos_q;
          if (s2_vld_q) begin
            last_key_q  <= key_rsp;
            have_last_q <= 1'b1;
          end
          if (scan_end) begin
            unique case (kind_q)
              SK_FINAL: begin
                more_q  <= scan_hit;
                done_q  <= 1'b1;
                busy_q  <= 1'b0;
                state_q <= ST_IDLE;
              end
              SK_PIVOT: begin
                if (scan_hit) begin
                  pivot_q     <= s2_pos_q;
                  pivot_key_q <= key_rsp;
                  kind_q      <= SK_SUCC;
                  state_q     <= ST_SCAN_INIT;
                end else begin
                  // already the last permutation: table untouched
                  more_q  <= 1'b0;
                  done_q  <= 1'b1;
                  busy_q  <= 1'b0;
                  state_q <= ST_IDLE;
                end
              end
              SK_SUCC: begin
                lo_q      <= pivot_q;
                hi_q      <= s2_pos_q;
                first_q   <= 1'b1;
                applied_q <= 1'b1;
                state_q   <= ST_SWAP_RA;
              end
            endcase
          end
        end
        ST_SWAP_RA: begin
          state_q <= ST_SWAP_RB;
        end
        ST_SWAP_RB: begin
          hold_q  <= row_rsp;
          state_q <= ST_SWAP_WA;
        end
        ST_SWAP_WA: begin
          state_q <= ST_SWAP_WB;
        end
        ST_SWAP_WB: begin
          first_q <= 1'b0;
          lo_q    <= lo_nxt;
          hi_q    <= hi_nxt;
          if (lo_nxt < hi_nxt) begin
            state_q <= ST_SWAP_RA;
          end else begin
            kind_q  <= SK_FINAL;
            state_q <= ST_SCAN_INIT;
          end
        end
      endcase
    end
  end

  lrp_row_store u_row_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (row_req),
    .rsp_o  (row_rsp)
  );

  lrp_key_store u_key_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (key_req),
    .key_o  (key_rsp)
  );

  assign busy           = busy_q;
  assign done_o         = done_q;
  assign key_out_o      = key_out_q;
  assign origin_out_o   = origin_out_q;
  assign previous_out_o = prev_out_q;
  assign applied_o      = applied_q;
  assign more_left_o    = more_q;

  // Result strobe only comes with the block released
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted transaction keeps the block busy and gives no result in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted transaction not held busy");

  // Swaps stay inside the active rows and the pair is ordered
  a_swap_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWAP_RA) |-> ((lo_q < hi_q) && (CW'(hi_q) < n_act)))
    else $error("swap pair out of order or out of range");

  // No memory write while idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (!row_req.wr_en && !key_req.wr_en && !row_req.clr_all))
    else $error("table changed while idle");

endmodule
